FILE: rtl/ptl_pkg.sv
package ptl_pkg;

  localparam int unsigned CAPACITY = 64;

  // Fixed field widths of the stream items.
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned POS_W   = 7;
  localparam int unsigned ROW_W   = 16;
  localparam int unsigned COL_W   = 16;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned COUNT_W = 7;

  localparam int unsigned ENTRY_W = ROW_W + COL_W + VAL_W;
  localparam int unsigned IN_W    = CMD_W + POS_W + ENTRY_W;
  localparam int unsigned OUT_W   = 1 + ENTRY_W + COUNT_W + 2;
  localparam int unsigned IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  // Entry count register and a common width for position compares.
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  // Read-out reduction: cells are ORed in groups, then the groups are ORed.
  localparam int unsigned GRP_N   = 8;
  localparam int unsigned NUM_GRP = (CAPACITY + GRP_N - 1) / GRP_N;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT  = 3'd0,
    CMD_DELETE  = 3'd1,
    CMD_READ    = 3'd2,
    CMD_REPLACE = 3'd3,
    CMD_CLEAR   = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GATHER,
    ST_REDUCE
  } state_e;

  typedef struct packed {
    logic take_left;
    logic take_right;
    logic load_in;
    logic capture;
    logic select;
  } cell_ctrl_t;

endpackage

FILE: rtl/positional_triple_list.sv
// An accepted command's result passes the cell capture register, the group OR register
// and the output register. A new command is taken only when idle with the output free;
// the slot chain updates in the accept cycle, and the read-out passes a two-level
// registered OR tree. Insert and delete shift slots from the addressed position on.
// Reset: the entry count clears to zero and no result is pending; slot contents
// are undefined until written. No clearing pass is needed.
module positional_triple_list (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // cmd[2:0], pos[9:3], row_in[25:10], col_in[41:26], value_in[73:42], zero fill
  input  logic [ptl_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // ok[0], row_out[16:1], col_out[32:17], value_out[64:33], count[71:65],
  // is_empty[72], is_full[73], zero fill
  output logic [ptl_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);

  localparam int unsigned NUM_SLOT = ptl_pkg::NUM_GRP * ptl_pkg::GRP_N;

  ptl_pkg::state_e state_q, state_d;

  logic                        accept;
  logic [ptl_pkg::CMD_W-1:0]   cmd;
  logic [ptl_pkg::POS_W-1:0]   pos;
  logic [ptl_pkg::ENTRY_W-1:0] t_in;
  logic [ptl_pkg::CMP_W-1:0]   pos_x, cnt_x;

  logic [ptl_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic                        ok_q, ok_d;
  logic                        out_valid_q, out_valid_d;
  logic [ptl_pkg::OUT_W-1:0]   out_q, out_d;

  logic ins_ok, del_ok, rd_ok, rep_ok, clr_ok;
  logic group_load;
  logic out_load;

  logic [ptl_pkg::ENTRY_W-1:0] slot_entry  [ptl_pkg::CAPACITY];
  logic [ptl_pkg::ENTRY_W-1:0] slot_masked [NUM_SLOT];
  logic [ptl_pkg::ENTRY_W-1:0] grp_out     [ptl_pkg::NUM_GRP];
  logic [ptl_pkg::ENTRY_W-1:0] read_data;

  assign cmd  = s_axis_tdata_i[ptl_pkg::CMD_W-1:0];
  assign pos  = s_axis_tdata_i[ptl_pkg::CMD_W +: ptl_pkg::POS_W];
  assign t_in = s_axis_tdata_i[ptl_pkg::CMD_W + ptl_pkg::POS_W +: ptl_pkg::ENTRY_W];

  assign pos_x = ptl_pkg::CMP_W'(pos);
  assign cnt_x = ptl_pkg::CMP_W'(cnt_q);

  assign accept = s_axis_tvalid_i & s_axis_tready_o;

  always_comb begin
    ins_ok = 1'b0;
    del_ok = 1'b0;
    rd_ok  = 1'b0;
    rep_ok = 1'b0;
    clr_ok = 1'b0;
    case (cmd)
      ptl_pkg::CMD_INSERT:  ins_ok = (pos_x <= cnt_x) &&
                                     (cnt_x < ptl_pkg::CMP_W'(ptl_pkg::CAPACITY));
      ptl_pkg::CMD_DELETE:  del_ok = (pos_x < cnt_x);
      ptl_pkg::CMD_READ:    rd_ok  = (pos_x < cnt_x);
      ptl_pkg::CMD_REPLACE: rep_ok = (pos_x < cnt_x);
      ptl_pkg::CMD_CLEAR:   clr_ok = 1'b1;
      default: ;
    endcase
  end

  // Slot chain: on insert slots past the position take their left neighbor; on delete
  // those at or past it the right one; slots at or past the count may hold anything.
  for (genvar i = 0; i < ptl_pkg::CAPACITY; i++) begin : g_slot
    ptl_pkg::cell_ctrl_t         ctrl;
    logic [ptl_pkg::ENTRY_W-1:0] left, right;
    logic                        at_pos, past_pos;

    assign at_pos   = (pos_x == ptl_pkg::CMP_W'(i));
    assign past_pos = (pos_x < ptl_pkg::CMP_W'(i));

    assign ctrl.load_in    = accept & (ins_ok | rep_ok) & at_pos;
    assign ctrl.take_left  = accept & ins_ok & past_pos;
    assign ctrl.take_right = accept & del_ok & (at_pos | past_pos);
    assign ctrl.capture    = accept;
    assign ctrl.select     = (rd_ok | del_ok) & at_pos;

    if (i == 0) begin : g_first
      assign left = t_in;
    end else begin : g_mid
      assign left = slot_entry[i-1];
    end
    if (i == ptl_pkg::CAPACITY - 1) begin : g_last
      assign right = slot_entry[i];
    end else begin : g_inner
      assign right = slot_entry[i+1];
    end

    ptl_cell u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl),
      .left_i   (left),
      .right_i  (right),
      .new_i    (t_in),
      .entry_o  (slot_entry[i]),
      .masked_o (slot_masked[i])
    );
  end

  for (genvar i = ptl_pkg::CAPACITY; i < NUM_SLOT; i++) begin : g_pad
    assign slot_masked[i] = '0;
  end

  for (genvar g = 0; g < ptl_pkg::NUM_GRP; g++) begin : g_grp
    logic [ptl_pkg::ENTRY_W-1:0] grp_in [ptl_pkg::GRP_N];
    for (genvar k = 0; k < ptl_pkg::GRP_N; k++) begin : g_in
      assign grp_in[k] = slot_masked[g * ptl_pkg::GRP_N + k];
    end
    ptl_or_group u_grp (
      .clk_i  (clk_i),
      .load_i (group_load),
      .data_i (grp_in),
      .data_o (grp_out[g])
    );
  end

  always_comb begin
    read_data = '0;
    for (int unsigned g = 0; g < ptl_pkg::NUM_GRP; g++) begin
      read_data = read_data | grp_out[g];
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ptl_pkg::ST_IDLE:   if (accept) state_d = ptl_pkg::ST_GATHER;
      ptl_pkg::ST_GATHER: state_d = ptl_pkg::ST_REDUCE;
      ptl_pkg::ST_REDUCE: state_d = ptl_pkg::ST_IDLE;
      default:            state_d = ptl_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    s_axis_tready_o = 1'b0;
    group_load      = 1'b0;
    out_load        = 1'b0;
    case (state_q)
      ptl_pkg::ST_IDLE:   s_axis_tready_o = ~out_valid_q | m_axis_tready_i;
      ptl_pkg::ST_GATHER: group_load = 1'b1;
      ptl_pkg::ST_REDUCE: out_load = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    ok_d  = ok_q;
    if (accept) begin
      ok_d = ins_ok | del_ok | rd_ok | rep_ok | clr_ok;
      if (clr_ok) begin
        cnt_d = '0;
      end else if (ins_ok) begin
        cnt_d = cnt_q + 1'b1;
      end else if (del_ok) begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
      out_d = {(cnt_q == ptl_pkg::CNT_W'(ptl_pkg::CAPACITY)),
               (cnt_q == '0),
               ptl_pkg::COUNT_W'(cnt_q),
               read_data,
               ok_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ptl_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ok_q  <= ok_d;
    out_q <= out_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = ptl_pkg::OUT_TDATA_W'(out_q);

endmodule

FILE: rtl/ptl_cell.sv
module ptl_cell (
  input  logic                        clk_i,
  input  ptl_pkg::cell_ctrl_t         ctrl_i,
  input  logic [ptl_pkg::ENTRY_W-1:0] left_i,
  input  logic [ptl_pkg::ENTRY_W-1:0] right_i,
  input  logic [ptl_pkg::ENTRY_W-1:0] new_i,
  output logic [ptl_pkg::ENTRY_W-1:0] entry_o,
  output logic [ptl_pkg::ENTRY_W-1:0] masked_o
);

  logic [ptl_pkg::ENTRY_W-1:0] entry_q, entry_d;
  logic [ptl_pkg::ENTRY_W-1:0] masked_q, masked_d;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.load_in) begin
      entry_d = new_i;
    end else if (ctrl_i.take_left) begin
      entry_d = left_i;
    end else if (ctrl_i.take_right) begin
      entry_d = right_i;
    end
  end

  // The old contents are captured before any shift lands on this cell.
  always_comb begin
    masked_d = masked_q;
    if (ctrl_i.capture) begin
      masked_d = ctrl_i.select ? entry_q : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q  <= entry_d;
    masked_q <= masked_d;
  end

  assign entry_o  = entry_q;
  assign masked_o = masked_q;

endmodule

FILE: rtl/ptl_or_group.sv
module ptl_or_group (
  input  logic                        clk_i,
  input  logic                        load_i,
  input  logic [ptl_pkg::ENTRY_W-1:0] data_i [ptl_pkg::GRP_N],
  output logic [ptl_pkg::ENTRY_W-1:0] data_o
);

  logic [ptl_pkg::ENTRY_W-1:0] acc_q, acc_d;
  logic [ptl_pkg::ENTRY_W-1:0] sum;

  always_comb begin
    sum = '0;
    for (int unsigned k = 0; k < ptl_pkg::GRP_N; k++) begin
      sum = sum | data_i[k];
    end
    acc_d = load_i ? sum : acc_q;
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign data_o = acc_q;

endmodule

FILE: test/ptl_checker.sv
`timescale 1ns / 1ps

module ptl_checker
  import ptl_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_tvalid_i,
  input  logic                   s_tready_i,
  input  logic [IN_TDATA_W-1:0]  s_tdata_i,
  input  logic                   m_tvalid_i,
  input  logic                   m_tready_i,
  input  logic [OUT_TDATA_W-1:0] m_tdata_i,
  output int                     fail_count_o,
  output int                     pending_o,
  output int                     occupancy_o
);

  localparam int unsigned SLOT_IW = $clog2(CAPACITY);

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [VAL_W-1:0] value;
  } triple_t;

  typedef struct packed {
    logic               ok;
    triple_t            t;
    logic [COUNT_W-1:0] count;
    logic               empty;
    logic               full;
  } answer_t;

  triple_t     slots[CAPACITY];
  int unsigned n_slots;
  answer_t     due_results[$];
  answer_t     want;

  task automatic note_miss(input string field, input logic [VAL_W-1:0] exp_v,
                           input logic [VAL_W-1:0] act_v);
    fail_count_o++;
    if (fail_count_o <= 10) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, exp_v, act_v);
    end
  endtask

  // Applies one command to the list copy and returns the result it gives.
  function automatic answer_t run_command(input logic [IN_TDATA_W-1:0] d);
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] pos;
    triple_t          t_in;
    answer_t          a;
    cmd        = d[CMD_W-1:0];
    pos        = d[CMD_W+:POS_W];
    t_in.row   = d[CMD_W+POS_W+:ROW_W];
    t_in.col   = d[CMD_W+POS_W+ROW_W+:COL_W];
    t_in.value = d[CMD_W+POS_W+ROW_W+COL_W+:VAL_W];
    a.ok = 1'b0;
    a.t  = '0;
    case (cmd)
      CMD_INSERT: begin
        if (pos <= n_slots && n_slots < CAPACITY) begin
          for (int i = n_slots; i > pos; i--) slots[i] = slots[i-1];
          slots[pos[SLOT_IW-1:0]] = t_in;
          n_slots++;
          a.ok = 1'b1;
        end
      end
      CMD_DELETE: begin
        if (pos < n_slots) begin
          a.t = slots[pos[SLOT_IW-1:0]];
          for (int i = pos; i + 1 < n_slots; i++) slots[i] = slots[i+1];
          n_slots--;
          a.ok = 1'b1;
        end
      end
      CMD_READ: begin
        if (pos < n_slots) begin
          a.t  = slots[pos[SLOT_IW-1:0]];
          a.ok = 1'b1;
        end
      end
      CMD_REPLACE: begin
        if (pos < n_slots) begin
          slots[pos[SLOT_IW-1:0]] = t_in;
          a.ok = 1'b1;
        end
      end
      CMD_CLEAR: begin
        n_slots = 0;
        a.ok = 1'b1;
      end
      default: ;
    endcase
    a.count = n_slots[COUNT_W-1:0];
    a.empty = (n_slots == 0);
    a.full  = (n_slots == CAPACITY);
    return a;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_slots = 0;
      due_results.delete();
      fail_count_o = 0;
    end else begin
      // A result always belongs to an earlier command, so it is checked before
      // the command of this same edge is queued.
      if (m_tvalid_i && m_tready_i) begin
        if (due_results.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) begin
            $display("%0t: result transfer with none expected, data %h", $time, m_tdata_i);
          end
        end else begin
          want = due_results.pop_front();
          if (m_tdata_i[0] !== want.ok) note_miss("ok", want.ok, m_tdata_i[0]);
          if (m_tdata_i[16:1] !== want.t.row) note_miss("row_out", want.t.row, m_tdata_i[16:1]);
          if (m_tdata_i[32:17] !== want.t.col) note_miss("col_out", want.t.col, m_tdata_i[32:17]);
          if (m_tdata_i[64:33] !== want.t.value) begin
            note_miss("value_out", want.t.value, m_tdata_i[64:33]);
          end
          if (m_tdata_i[71:65] !== want.count) note_miss("count", want.count, m_tdata_i[71:65]);
          if (m_tdata_i[72] !== want.empty) note_miss("is_empty", want.empty, m_tdata_i[72]);
          if (m_tdata_i[73] !== want.full) note_miss("is_full", want.full, m_tdata_i[73]);
        end
      end
      if (s_tvalid_i && s_tready_i) due_results.push_back(run_command(s_tdata_i));
    end
    pending_o   = due_results.size();
    occupancy_o = n_slots;
  end

endmodule

FILE: test/tb_positional_triple_list.sv
`timescale 1ns / 1ps

module tb_positional_triple_list;
  import ptl_pkg::*;

  localparam logic [CMD_W-1:0] CMD_LAST    = '1;
  localparam logic [POS_W-1:0] POS_LAST    = '1;
  localparam int unsigned      IDLE_PCT    = 31;
  localparam int unsigned      HOLD_CYCLES = 150;
  localparam int unsigned      NUM_RANDOM  = 400;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_valid;
  logic                   s_ready;
  logic [IN_TDATA_W-1:0]  s_data;
  logic                   m_valid;
  logic                   m_ready;
  logic [OUT_TDATA_W-1:0] m_data;
  int                     fail_count;
  int                     pending;
  int                     occupancy;
  bit                     calm;
  bit                     hold_req;

  positional_triple_list i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  ptl_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_valid),
    .s_tready_i   (s_ready),
    .s_tdata_i    (s_data),
    .m_tvalid_i   (m_valid),
    .m_tready_i   (m_ready),
    .m_tdata_i    (m_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .occupancy_o  (occupancy)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  initial begin
    #2_000_000;
    $display("FAIL positional_triple_list");
    $finish;
  end

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin
    bit held;
    held    = 1'b0;
    m_ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !held) begin
        held = 1'b1;
        m_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else begin
        m_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                              input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col,
                              input logic [VAL_W-1:0] value);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= IN_TDATA_W'({value, col, row, pos, cmd});
    do @(posedge clk_i); while (!s_ready);
    @(negedge clk_i);
  endtask

  initial begin
    int               occ;
    int               r;
    bit               grow;
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] pos;
    s_valid  = 1'b0;
    s_data   = '0;
    rst_ni   = 1'b0;
    calm     = 1'b0;
    hold_req = 1'b0;
    grow     = 1'b1;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Commands on the empty list all fail.
    send_command(CMD_READ, 0, 16'h1111, 16'h2222, 32'h3333_3333);
    send_command(CMD_DELETE, 0, 16'h0, 16'h0, 32'h0);
    send_command(CMD_REPLACE, 0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_command(CMD_INSERT, 1, 16'h4444, 16'h5555, 32'h6666_6666);
    // Insert at the front, append at the end, then insert at the front again.
    send_command(CMD_INSERT, 0, 16'hFFFF, 16'h0000, 32'h8000_0000);
    send_command(CMD_INSERT, 1, 16'h0000, 16'hFFFF, 32'h7FFF_FFFF);
    send_command(CMD_INSERT, 0, 16'h1234, 16'h5678, 32'hFFFF_FFFF);
    send_command(CMD_READ, 0, 16'h0, 16'h0, 32'h0);
    send_command(CMD_READ, 1, 16'h0, 16'h0, 32'h0);
    send_command(CMD_READ, 2, 16'h0, 16'h0, 32'h0);
    send_command(CMD_READ, 3, 16'h0, 16'h0, 32'h0);
    send_command(CMD_REPLACE, 2, 16'hAAAA, 16'h5555, 32'h55AA_55AA);
    send_command(CMD_READ, 2, 16'h0, 16'h0, 32'h0);
    // Delete at the position equal to the count is rejected.
    send_command(CMD_DELETE, 3, 16'h0, 16'h0, 32'h0);
    send_command(CMD_DELETE, 1, 16'h0, 16'h0, 32'h0);
    send_command(CMD_READ, 1, 16'h0, 16'h0, 32'h0);
    send_command(CMD_READ, POS_LAST, 16'h0, 16'h0, 32'h0);
    for (int c = CMD_CLEAR + 1; c <= CMD_LAST; c++) begin
      send_command(CMD_W'(c), 0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    end
    send_command(CMD_INSERT, 3, 16'h7777, 16'h8888, 32'h9999_9999);
    send_command(CMD_CLEAR, POS_LAST, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_command(CMD_READ, 0, 16'h0, 16'h0, 32'h0);
    send_command(CMD_DELETE, 0, 16'h0, 16'h0, 32'h0);
    send_command(CMD_INSERT, 0, 16'hBEEF, 16'hCAFE, 32'h0000_0001);

    // Random part: alternate between filling the list up to capacity and
    // draining it, so inserts into a full list and the deep shifts are reached.
    for (int k = 0; k < NUM_RANDOM; k++) begin
      if (k == 150) begin
        calm     = 1'b1;
        hold_req = 1'b1;
      end
      if (k == 240) calm = 1'b0;
      if (k == 300) begin
        s_valid <= 1'b0;
        @(negedge clk_i);
        while (pending != 0) @(negedge clk_i);
      end
      occ = occupancy;
      if (grow && occ == CAPACITY && $urandom_range(3) == 0) grow = 1'b0;
      if (!grow && occ == 0 && $urandom_range(3) == 0) grow = 1'b1;
      r = $urandom_range(99);
      if (r < 3) cmd = CMD_W'($urandom_range(CMD_LAST, CMD_CLEAR + 1));
      else if (!grow && r < 4) cmd = CMD_CLEAR;
      else if (grow) begin
        cmd = (r < 70) ? CMD_INSERT : (r < 80) ? CMD_DELETE : (r < 90) ? CMD_READ : CMD_REPLACE;
      end else begin
        cmd = (r < 60) ? CMD_DELETE : (r < 70) ? CMD_INSERT : (r < 85) ? CMD_READ : CMD_REPLACE;
      end
      if ($urandom_range(99) < 15) pos = POS_W'($urandom_range(POS_LAST));
      else if (cmd == CMD_INSERT) pos = POS_W'($urandom_range(occ));
      else pos = (occ == 0) ? '0 : POS_W'($urandom_range(occ - 1));
      send_command(cmd, pos, ROW_W'($urandom), COL_W'($urandom), $urandom);
    end
    s_valid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("PASS positional_triple_list");
    end else begin
      $display("FAIL positional_triple_list");
    end
    $finish;
  end

endmodule
